@@ hdl/slxfp_pkg.sv @@
// ---------------------------------------------------------------------------
// slxfp_pkg: shared constants for the sync/length/XOR frame parser
// Phase codes, result kind codes and field widths used by the parser.
// ---------------------------------------------------------------------------
package slxfp_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int PHASE_W = 3;
    localparam int OUT_W   = 40;

    // Reset value of the sync byte register
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hFF;

    // Parser phase codes
    localparam logic [PHASE_W-1:0] PH_SYNC = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CMD  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SUM  = 3'd4;

    // Result kind codes
    localparam logic [KIND_W-1:0] K_DISCARD = 3'd0;
    localparam logic [KIND_W-1:0] K_SYNC    = 3'd1;
    localparam logic [KIND_W-1:0] K_CMD     = 3'd2;
    localparam logic [KIND_W-1:0] K_LEN     = 3'd3;
    localparam logic [KIND_W-1:0] K_DATA    = 3'd4;
    localparam logic [KIND_W-1:0] K_SUM     = 3'd5;

    // Fields of one result word before packing
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] command_out;
        logic [BYTE_W-1:0] length_out;
        logic              frame_done;
        logic              checksum_ok;
    } result_t;

endpackage

@@ hdl/sync_len_xor_frame_parser.sv @@
// ---------------------------------------------------------------------------
// sync_len_xor_frame_parser
// Deframes sync/command/length/payload/checksum packets from a byte stream
// and classifies every received byte in one result word.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Signals                          | Content
//  --------+-----------+----------------------------------+---------------------
//  s_      | in        | s_tvalid s_tready s_tdata[7:0]   | received byte
//  m_      | out       | m_tvalid m_tready m_tdata[39:0]  | classified byte
//          |           | m_tuser[2:0] m_tlast             | kind, end of frame
//  cfg_    | in        | cfg_valid cfg_ready cfg_data[7:0]| sync byte value
//
// One byte is taken per cycle unless the output stalls; its result appears in
// the cycle after acceptance. The header state and the running XOR are updated
// at the accepting edge, so a byte may follow in the very next cycle; the
// output register sets the rate. A byte is accepted while the output register
// is empty or being emptied, so an output stall holds the input after one word.
// Reset (rst_n low, asynchronous) returns the parser to waiting for sync,
// clears the held header and sets the sync byte to 0xFF.
// The configuration port is always ready.
//
module sync_len_xor_frame_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] value, [15:8] payload_index,
                                   // [23:16] command_out, [31:24] length_out,
                                   // [32] checksum_ok, [39:33] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,   // frame_done
    // Configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // [7:0] sync_byte
);

    logic [slxfp_pkg::BYTE_W-1:0]  sync_reg;
    logic [slxfp_pkg::PHASE_W-1:0] phase_reg;
    logic [slxfp_pkg::PHASE_W-1:0] phase_next;
    logic [slxfp_pkg::BYTE_W-1:0]  cmd_reg;
    logic [slxfp_pkg::BYTE_W-1:0]  cmd_next;
    logic [slxfp_pkg::BYTE_W-1:0]  len_reg;
    logic [slxfp_pkg::BYTE_W-1:0]  len_next;
    logic [slxfp_pkg::BYTE_W-1:0]  count_reg;
    logic [slxfp_pkg::BYTE_W-1:0]  count_next;
    logic [slxfp_pkg::BYTE_W-1:0]  xor_reg;
    logic [slxfp_pkg::BYTE_W-1:0]  xor_next;
    logic                          out_valid_reg;
    slxfp_pkg::result_t            res_reg;
    slxfp_pkg::result_t            res_next;
    logic                          s_accept;
    logic [slxfp_pkg::BYTE_W:0]    count_inc;

    // Handshakes
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Sync byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= slxfp_pkg::SYNC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sync_reg <= cfg_data;
        end
    end

    // Next parser state and result for the byte at the input
    assign count_inc = {1'b0, count_reg} + {{slxfp_pkg::BYTE_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        res_next.kind          = slxfp_pkg::K_DISCARD;
        res_next.payload_index = '0;
        res_next.frame_done    = 1'b0;
        res_next.checksum_ok   = 1'b0;
        case (phase_reg)
            slxfp_pkg::PH_CMD:
            begin
                res_next.kind = slxfp_pkg::K_CMD;
                cmd_next      = s_tdata;
                xor_next      = xor_reg ^ s_tdata;
                phase_next    = slxfp_pkg::PH_LEN;
            end
            slxfp_pkg::PH_LEN:
            begin
                res_next.kind = slxfp_pkg::K_LEN;
                len_next      = s_tdata;
                xor_next      = xor_reg ^ s_tdata;
                count_next    = '0;
                phase_next    = (s_tdata != '0) ? slxfp_pkg::PH_DATA : slxfp_pkg::PH_SUM;
            end
            slxfp_pkg::PH_DATA:
            begin
                res_next.kind          = slxfp_pkg::K_DATA;
                res_next.payload_index = count_reg;
                xor_next               = xor_reg ^ s_tdata;
                count_next             = count_inc[slxfp_pkg::BYTE_W-1:0];
                if (count_inc >= {1'b0, len_reg})
                begin
                    phase_next = slxfp_pkg::PH_SUM;
                end
            end
            slxfp_pkg::PH_SUM:
            begin
                res_next.kind        = slxfp_pkg::K_SUM;
                res_next.frame_done  = 1'b1;
                res_next.checksum_ok = (s_tdata == xor_reg);
                phase_next           = slxfp_pkg::PH_SYNC;
            end
            default:
            begin
                // Waiting for sync; unused codes behave the same way.
                if (s_tdata == sync_reg)
                begin
                    res_next.kind = slxfp_pkg::K_SYNC;
                    xor_next      = '0;
                    phase_next    = slxfp_pkg::PH_CMD;
                end
                else
                begin
                    count_next = '0;
                    phase_next = slxfp_pkg::PH_SYNC;
                end
            end
        endcase
        res_next.value       = s_tdata;
        res_next.command_out = cmd_next;
        res_next.length_out  = len_next;
    end

    // Parser state, updated on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= slxfp_pkg::PH_SYNC;
            cmd_reg   <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            xor_reg   <= '0;
        end
        else if (s_accept)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            res_reg <= res_next;
        end
    end

    // Pack the result word
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.frame_done;
    assign m_tdata  = {7'd0, res_reg.checksum_ok, res_reg.length_out,
                       res_reg.command_out, res_reg.payload_index, res_reg.value};

`ifndef ASSERT_OFF
    // The end-of-frame mark comes only with a checksum byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == slxfp_pkg::K_SUM))
        else $error("frame end without checksum kind");

    // A checksum match is reported only on the last byte of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[32]) |-> m_tlast)
        else $error("checksum_ok outside frame end");

    // A non-zero payload index belongs to a payload byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[15:8] != 8'd0)) |-> (m_tuser == slxfp_pkg::K_DATA))
        else $error("payload index on non-payload byte");

    // After a checksum byte the parser waits for sync again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (phase_reg == slxfp_pkg::PH_SUM)) |=> (phase_reg == slxfp_pkg::PH_SYNC))
        else $error("parser did not return to sync after checksum");

    // An empty output register never blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");
`endif

endmodule
